[hw/rtl/dpf_pkg.sv]
// shared types, widths, command codes and defaults for the deduplicating packet fifo
package dpf_pkg;

    localparam int ID_W    = 20;
    localparam int TIME_W  = 30;
    localparam int LIMIT_W = 5;
    localparam int COUNT_W = 5;
    localparam int CMD_W   = 2;

    localparam int CAPACITY_DEF = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FWD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;

    // one stored packet
    typedef struct packed {
        logic [ID_W-1:0]   src;
        logic [ID_W-1:0]   dst;
        logic [TIME_W-1:0] ts;
    } entry_t;

    // one incoming request
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   src;
        logic [ID_W-1:0]   dst;
        logic [TIME_W-1:0] ts;
        logic [TIME_W-1:0] ws;
        logic [TIME_W-1:0] we;
    } req_t;

    // one result
    typedef struct packed {
        logic               ok;
        logic [ID_W-1:0]    src;
        logic [ID_W-1:0]    dst;
        logic [TIME_W-1:0]  ts;
        logic [COUNT_W-1:0] cnt;
    } rslt_t;

endpackage

[hw/rtl/dedup_packet_fifo_with_range_count.sv]
// top level of the deduplicating packet fifo with range count
//
// Bounded fifo of (source, destination, timestamp) packets held in one
// single-port-read memory of CAPACITY entries. Each request gives exactly one
// result. An add scans every held packet for an exact copy (result ok 0 if
// found), otherwise stores the packet, dropping the oldest first when the
// occupancy has reached memory_limit (0 acts as 1, above CAPACITY acts as
// CAPACITY). A forward pops the oldest packet (ok 0 when empty). A count scans
// every held packet and returns how many match the destination with a
// timestamp inside the inclusive window, low 5 bits only. Requests are
// handled one at a time; add and count scan the store, which reads one stored
// packet per cycle through the memory read port, and an unknown command
// gives a result with ok 0. A finished result waits in the output register,
// so the next request can be taken while it is still held. The user must
// write memory_limit only while idle; the block itself does not enforce this.
module dedup_packet_fifo_with_range_count #(
    parameter int CAPACITY = dpf_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [dpf_pkg::LIMIT_W-1:0]   cfg_wr_data,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dpf_pkg::CMD_W-1:0]     s_command,
    input  logic [dpf_pkg::ID_W-1:0]      s_source,
    input  logic [dpf_pkg::ID_W-1:0]      s_destination,
    input  logic [dpf_pkg::TIME_W-1:0]    s_timestamp,
    input  logic [dpf_pkg::TIME_W-1:0]    s_window_start,
    input  logic [dpf_pkg::TIME_W-1:0]    s_window_end,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_ok,
    output logic [dpf_pkg::ID_W-1:0]      m_out_source,
    output logic [dpf_pkg::ID_W-1:0]      m_out_destination,
    output logic [dpf_pkg::TIME_W-1:0]    m_out_timestamp,
    output logic [dpf_pkg::COUNT_W-1:0]   m_match_count
);

    localparam int PTR_W = $clog2(CAPACITY);

    // eviction threshold register
    logic [dpf_pkg::LIMIT_W-1:0] limit_reg;

    // output register, decouples the sequencer from the result channel
    logic                        m_valid_reg;
    dpf_pkg::rslt_t              m_rslt_reg;

    dpf_pkg::req_t               req;
    logic                        rslt_valid;
    logic                        rslt_ready;
    dpf_pkg::rslt_t              rslt;

    logic                        rd_en;
    logic [PTR_W-1:0]            rd_addr;
    dpf_pkg::entry_t             rd_data;
    logic                        wr_en;
    logic [PTR_W-1:0]            wr_addr;
    dpf_pkg::entry_t             wr_data;

    always_comb begin
        req.cmd = s_command;
        req.src = s_source;
        req.dst = s_destination;
        req.ts  = s_timestamp;
        req.ws  = s_window_start;
        req.we  = s_window_end;
    end

    // result register may load when empty or being drained this cycle
    assign rslt_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= dpf_pkg::LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (rslt_valid && rslt_ready) begin
                m_valid_reg <= 1'b1;
                m_rslt_reg  <= rslt;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    dpf_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .limit      (limit_reg),
        .req_valid  (s_valid),
        .req_ready  (s_ready),
        .req        (req),
        .rslt_valid (rslt_valid),
        .rslt_ready (rslt_ready),
        .rslt       (rslt),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    dpf_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_valid           = m_valid_reg;
    assign m_ok              = m_rslt_reg.ok;
    assign m_out_source      = m_rslt_reg.src;
    assign m_out_destination = m_rslt_reg.dst;
    assign m_out_timestamp   = m_rslt_reg.ts;
    assign m_match_count     = m_rslt_reg.cnt;

endmodule

[hw/rtl/dpf_mem.sv]
// packet store: one write port, one read port, registered read data
module dpf_mem #(
    parameter int CAPACITY = dpf_pkg::CAPACITY_DEF
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  dpf_pkg::entry_t             wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(CAPACITY)-1:0] rd_addr,
    output dpf_pkg::entry_t             rd_data
);

    dpf_pkg::entry_t mem_reg [CAPACITY];
    dpf_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/dpf_seq.sv]
// sequencer: pointers, occupancy, store scan for duplicate check and range count
module dpf_seq #(
    parameter int CAPACITY = dpf_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [dpf_pkg::LIMIT_W-1:0]   limit,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  dpf_pkg::req_t                 req,
    output logic                          rslt_valid,
    input  logic                          rslt_ready,
    output dpf_pkg::rslt_t                rslt,
    output logic                          rd_en,
    output logic [$clog2(CAPACITY)-1:0]   rd_addr,
    input  dpf_pkg::entry_t               rd_data,
    output logic                          wr_en,
    output logic [$clog2(CAPACITY)-1:0]   wr_addr,
    output dpf_pkg::entry_t               wr_data
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CNT_W = (OCC_W > dpf_pkg::COUNT_W) ? OCC_W : dpf_pkg::COUNT_W;
    localparam int SUM_W = OCC_W + 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_CATCH,
        S_RESULT
    } state_t;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    state_t                        state_reg;
    logic [PTR_W-1:0]              head_reg;
    logic [PTR_W-1:0]              tail_reg;
    logic [OCC_W-1:0]              occ_reg;
    logic [PTR_W-1:0]              scan_ptr_reg;
    logic [OCC_W-1:0]              iss_reg;
    logic                          pend_reg;
    logic                          dup_reg;
    logic [CNT_W-1:0]              cnt_reg;
    dpf_pkg::req_t                 req_reg;
    dpf_pkg::rslt_t                rslt_reg;

    dpf_pkg::entry_t               key;
    logic                          scan_busy;
    logic                          scan_done;
    logic [dpf_pkg::LIMIT_W-1:0]   lim_eff;
    logic                          at_limit;
    logic                          evict;
    logic                          add_go;
    logic                          hit_dup;
    logic                          hit_cnt;

    always_comb begin
        key.src   = req_reg.src;
        key.dst   = req_reg.dst;
        key.ts    = req_reg.ts;
        scan_busy = (iss_reg != occ_reg);
        scan_done = (state_reg == S_SCAN) && !scan_busy && !pend_reg;
        lim_eff   = (limit == '0) ? dpf_pkg::LIMIT_W'(1) : limit;
        at_limit  = (occ_reg == OCC_W'(CAPACITY)) || (CNT_W'(occ_reg) >= CNT_W'(lim_eff));
        evict     = at_limit && (occ_reg != '0);
        add_go    = scan_done && (req_reg.cmd == dpf_pkg::CMD_ADD) && !dup_reg;
        hit_dup   = pend_reg && (rd_data == key);
        hit_cnt   = pend_reg && (rd_data.dst == req_reg.dst)
                    && (rd_data.ts >= req_reg.ws) && (rd_data.ts <= req_reg.we);
    end

    assign rd_en      = ((state_reg == S_SCAN) && scan_busy) || (state_reg == S_FETCH);
    assign rd_addr    = (state_reg == S_FETCH) ? head_reg : scan_ptr_reg;
    assign wr_en      = add_go;
    assign wr_addr    = tail_reg;
    assign wr_data    = key;
    assign req_ready  = (state_reg == S_IDLE);
    assign rslt_valid = (state_reg == S_RESULT);
    assign rslt       = rslt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            pend_reg <= (state_reg == S_SCAN) && scan_busy;
            unique case (state_reg)
                S_IDLE: begin
                    if (req_valid) begin
                        req_reg      <= req;
                        scan_ptr_reg <= head_reg;
                        iss_reg      <= '0;
                        dup_reg      <= 1'b0;
                        cnt_reg      <= '0;
                        rslt_reg     <= '0;
                        unique case (req.cmd) inside
                            dpf_pkg::CMD_ADD,
                            dpf_pkg::CMD_COUNT: state_reg <= S_SCAN;
                            dpf_pkg::CMD_FWD:
                                state_reg <= (occ_reg != '0) ? S_FETCH : S_RESULT;
                            default:            state_reg <= S_RESULT;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_busy) begin
                        scan_ptr_reg <= next_slot(scan_ptr_reg);
                        iss_reg      <= OCC_W'(iss_reg + 1'b1);
                    end
                    if (hit_dup) begin
                        dup_reg <= 1'b1;
                    end
                    if (hit_cnt) begin
                        cnt_reg <= CNT_W'(cnt_reg + 1'b1);
                    end
                    if (scan_done) begin
                        state_reg <= S_RESULT;
                        if (req_reg.cmd == dpf_pkg::CMD_COUNT) begin
                            rslt_reg.cnt <= cnt_reg[dpf_pkg::COUNT_W-1:0];
                        end
                        if (add_go) begin
                            rslt_reg.ok <= 1'b1;
                            tail_reg    <= next_slot(tail_reg);
                            if (evict) begin
                                head_reg <= next_slot(head_reg);
                            end else begin
                                occ_reg <= OCC_W'(occ_reg + 1'b1);
                            end
                        end
                    end
                end
                S_FETCH: begin
                    state_reg <= S_CATCH;
                end
                S_CATCH: begin
                    rslt_reg.ok  <= 1'b1;
                    rslt_reg.src <= rd_data.src;
                    rslt_reg.dst <= rd_data.dst;
                    rslt_reg.ts  <= rd_data.ts;
                    head_reg     <= next_slot(head_reg);
                    occ_reg      <= OCC_W'(occ_reg - 1'b1);
                    state_reg    <= S_RESULT;
                end
                S_RESULT: begin
                    if (rslt_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // tail must sit occupancy slots past head, modulo the store depth
    logic [SUM_W-1:0] ptr_sum;
    logic [SUM_W-1:0] ptr_wrap;

    assign ptr_sum  = SUM_W'(head_reg) + SUM_W'(occ_reg);
    assign ptr_wrap = (ptr_sum >= SUM_W'(CAPACITY)) ? SUM_W'(ptr_sum - SUM_W'(CAPACITY))
                                                     : ptr_sum;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_ptr_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_reg == ptr_wrap[PTR_W-1:0])
        else $error("head, tail and occupancy disagree");

    a_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && wr_en))
        else $error("store read and write in the same cycle");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (iss_reg <= occ_reg))
        else $error("scan ran past the held packets");

endmodule
